// ===== rtl/mbpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the multi-button press classifier.
// No dependencies.
package mbpc_pkg;

	// Geometry
	localparam int NUM_BUTTONS = 6;
	localparam int PIN_BITS    = 6;
	localparam int CNT_W       = 16;
	localparam int TICK_W      = 8;
	localparam int BTN_W       = 3;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 16;

	// Register reset values
	localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 8'd20;
	localparam logic [CNT_W-1:0]  DEBOUNCE_RST    = 16'd40;
	localparam logic [CNT_W-1:0]  LONG_PRESS_RST  = 16'd500;
	localparam logic [CNT_W-1:0]  HOLD_REPEAT_RST = 16'd200;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TICK_PERIOD = 4'd0,
		CFG_DEBOUNCE    = 4'd1,
		CFG_LONG_PRESS  = 4'd2,
		CFG_HOLD_REPEAT = 4'd3
	} cfg_reg_t;

	// Event codes
	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_DOWN  = 3'd1,
		EV_SHORT = 3'd2,
		EV_LONG  = 3'd3,
		EV_HOLD  = 3'd4
	} ev_code_t;

	// Timing configuration shared by all lanes
	typedef struct packed {
		logic [TICK_W-1:0] tick_period;
		logic [CNT_W-1:0]  debounce;
		logic [CNT_W-1:0]  long_press;
		logic [CNT_W-1:0]  hold_repeat;
	} cfg_t;

	// Result of the priority merge
	typedef struct packed {
		logic                      any_event;
		ev_code_t                  code;
		logic [BTN_W-1:0]          button;
		logic [NUM_BUTTONS-1:0]    commit;
	} merge_t;

	// Saturating add of a tick period onto a 16-bit counter
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [TICK_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {{(CNT_W - TICK_W + 1){1'b0}}, b};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

// ===== rtl/mbpc_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: scan input, event output, register writes.
// Depends on mbpc_pkg.
interface mbpc_in_if;
	logic                             valid;
	logic                             ready;
	logic [mbpc_pkg::PIN_BITS-1:0]    pin_levels;
	modport source (output valid, output pin_levels, input ready);
	modport sink   (input valid, input pin_levels, output ready);
endinterface

interface mbpc_out_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    event_code;
	logic [mbpc_pkg::BTN_W-1:0]    event_button;
	modport source (output valid, output event_code, output event_button, input ready);
	modport sink   (input valid, input event_code, input event_button, output ready);
endinterface

interface mbpc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mbpc_pkg::CFG_IDX_W-1:0]    index;
	logic [mbpc_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mbpc_lane.sv =====
`timescale 1ns / 1ps
// One button lane: debounce, duration and hold-repeat counters plus event decode.
// Depends on mbpc_pkg.
module mbpc_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  mbpc_pkg::cfg_t      cfg,
	input  logic                pressed,
	input  logic                commit,
	output mbpc_pkg::ev_code_t  ev
);

	logic                        is_pressed_q, is_pressed_d;
	logic                        hold_fired_q, hold_fired_d;
	logic [mbpc_pkg::CNT_W-1:0]  debounce_q, debounce_d;
	logic [mbpc_pkg::CNT_W-1:0]  duration_q, duration_d;
	logic [mbpc_pkg::CNT_W-1:0]  since_hold_q, since_hold_d;
	logic [mbpc_pkg::CNT_W-1:0]  db_sum, dur_sum, slh_sum;

	assign db_sum  = mbpc_pkg::sat_add(debounce_q, cfg.tick_period);
	assign dur_sum = mbpc_pkg::sat_add(duration_q, cfg.tick_period);
	assign slh_sum = mbpc_pkg::sat_add(since_hold_q, cfg.tick_period);

	// Next state and event for this tick
	always_comb begin
		is_pressed_d = is_pressed_q;
		hold_fired_d = hold_fired_q;
		debounce_d   = debounce_q;
		duration_d   = duration_q;
		since_hold_d = since_hold_q;
		ev           = mbpc_pkg::EV_NONE;
		if (pressed && !is_pressed_q) begin
			// debouncing a new press
			debounce_d = db_sum;
			if (db_sum >= cfg.debounce) begin
				is_pressed_d = 1'b1;
				duration_d   = '0;
				debounce_d   = '0;
				hold_fired_d = 1'b0;
				since_hold_d = '0;
				ev           = mbpc_pkg::EV_DOWN;
			end
		end else if (pressed) begin
			// held: first hold at long threshold, then every repeat interval
			duration_d   = dur_sum;
			since_hold_d = slh_sum;
			if (dur_sum >= cfg.long_press) begin
				if (!hold_fired_q) begin
					hold_fired_d = 1'b1;
					since_hold_d = '0;
					ev           = mbpc_pkg::EV_HOLD;
				end else if (slh_sum >= cfg.hold_repeat) begin
					since_hold_d = '0;
					ev           = mbpc_pkg::EV_HOLD;
				end
			end
		end else begin
			// released: immediate, classified by duration
			debounce_d = '0;
			if (is_pressed_q) begin
				ev           = (duration_q >= cfg.long_press) ? mbpc_pkg::EV_LONG
				                                              : mbpc_pkg::EV_SHORT;
				is_pressed_d = 1'b0;
				duration_d   = '0;
				hold_fired_d = 1'b0;
			end
		end
	end

	// State registers, updated only when the merge lets this lane commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_pressed_q <= 1'b0;
			hold_fired_q <= 1'b0;
			debounce_q   <= '0;
			duration_q   <= '0;
			since_hold_q <= '0;
		end else if (commit) begin
			is_pressed_q <= is_pressed_d;
			hold_fired_q <= hold_fired_d;
			debounce_q   <= debounce_d;
			duration_q   <= duration_d;
			since_hold_q <= since_hold_d;
		end
	end

endmodule

// ===== rtl/mbpc_merge.sv =====
`timescale 1ns / 1ps
// Priority merge: lowest-index lane with an event wins; lanes above it hold state.
// Depends on mbpc_pkg.
module mbpc_merge (
	input  logic                                          accept,
	input  mbpc_pkg::ev_code_t [mbpc_pkg::NUM_BUTTONS-1:0] lane_ev,
	output mbpc_pkg::merge_t                              result
);

	always_comb begin
		logic found;
		found            = 1'b0;
		result.any_event = 1'b0;
		result.code      = mbpc_pkg::EV_NONE;
		result.button    = '0;
		result.commit    = '0;
		for (int i = 0; i < mbpc_pkg::NUM_BUTTONS; i++) begin
			result.commit[i] = accept && !found;
			if (!found && lane_ev[i] != mbpc_pkg::EV_NONE) begin
				found            = 1'b1;
				result.any_event = 1'b1;
				result.code      = lane_ev[i];
				result.button    = mbpc_pkg::BTN_W'(i);
			end
		end
	end

endmodule

// ===== rtl/multi_button_press_classifier_core.sv =====
`timescale 1ns / 1ps
// Top level of the multi-button press classifier: config registers, lanes,
// merge and output register. Depends on mbpc_pkg, mbpc_ifs, mbpc_lane, mbpc_merge.
//
//   channel  dir  payload                      item
//   in_ch    in   pin_levels[5:0]              one scan tick
//   out_ch   out  event_code[2:0], event_button[2:0]  one result per tick
//   cfg      in   index[3:0], data[15:0]       one register write
//
// One tick per cycle unless out_ch stalls: every lane evaluates its button in
// parallel, the merge picks the first event, and the result lands in a one-entry
// output register in the cycle after the tick is taken. A new tick is taken while
// out_ch is empty or being read. When out_ch stalls with a result pending,
// in_ch.ready drops until it drains. Reset clears all lane counters and loads the
// register defaults; cfg.ready is always high.
module multi_button_press_classifier_core (
	input  logic        clk,
	input  logic        arst_n,
	mbpc_in_if.sink     in_ch,
	mbpc_out_if.source  out_ch,
	mbpc_cfg_if.sink    cfg
);

	mbpc_pkg::cfg_t                                 cfg_q;
	logic [mbpc_pkg::NUM_BUTTONS-1:0]               pressed;
	mbpc_pkg::ev_code_t [mbpc_pkg::NUM_BUTTONS-1:0] lane_ev;
	mbpc_pkg::merge_t                               merged;
	logic                                           accept;
	logic [mbpc_pkg::BTN_W-1:0]                     last_btn_q, btn_now;
	logic                                           out_valid_q;
	mbpc_pkg::ev_code_t                             out_code_q;
	logic [mbpc_pkg::BTN_W-1:0]                     out_btn_q;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_period <= mbpc_pkg::TICK_PERIOD_RST;
			cfg_q.debounce    <= mbpc_pkg::DEBOUNCE_RST;
			cfg_q.long_press  <= mbpc_pkg::LONG_PRESS_RST;
			cfg_q.hold_repeat <= mbpc_pkg::HOLD_REPEAT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				mbpc_pkg::CFG_TICK_PERIOD: cfg_q.tick_period <= cfg.data[mbpc_pkg::TICK_W-1:0];
				mbpc_pkg::CFG_DEBOUNCE:    cfg_q.debounce    <= cfg.data;
				mbpc_pkg::CFG_LONG_PRESS:  cfg_q.long_press  <= cfg.data;
				mbpc_pkg::CFG_HOLD_REPEAT: cfg_q.hold_repeat <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input handshake: output register free or draining this cycle
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	// Lanes; buttons without a pin bit always read as released
	for (genvar i = 0; i < mbpc_pkg::NUM_BUTTONS; i++) begin : g_lane
		if (i < mbpc_pkg::PIN_BITS) begin : g_pin
			assign pressed[i] = ~in_ch.pin_levels[i];
		end else begin : g_nopin
			assign pressed[i] = 1'b0;
		end
		mbpc_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.cfg     (cfg_q),
			.pressed (pressed[i]),
			.commit  (merged.commit[i]),
			.ev      (lane_ev[i])
		);
	end

	mbpc_merge u_merge (
		.accept  (accept),
		.lane_ev (lane_ev),
		.result  (merged)
	);

	assign btn_now = merged.any_event ? merged.button : last_btn_q;

	// Last event button and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_btn_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				last_btn_q  <= btn_now;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_code_q <= merged.code;
			out_btn_q  <= btn_now;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.event_code   = out_code_q;
	assign out_ch.event_button = out_btn_q;

endmodule

// ===== rtl/mbpc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the classifier core, bound to the top level.
// Depends on mbpc_pkg and multi_button_press_classifier_core.
module mbpc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [2:0]                  event_code,
	input logic [mbpc_pkg::BTN_W-1:0]  event_button
);

	logic [mbpc_pkg::BTN_W-1:0] last_btn_q;

	// Button of the most recently delivered item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_btn_q <= '0;
		end else if (out_valid && out_ready) begin
			last_btn_q <= event_button;
		end
	end

	// A pending result stays until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// No tick taken while a result is stuck in the output register
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted over a stalled result");

	// Every accepted tick yields a result next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("missing result after accepted tick");

	// Event codes stay in the defined range
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_code <= 3'(mbpc_pkg::EV_HOLD))
		else $error("undefined event code");

	// Without an event the button repeats the previous one
	a_btn_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == 3'(mbpc_pkg::EV_NONE) |-> event_button == last_btn_q)
		else $error("event button changed without an event");

endmodule

bind multi_button_press_classifier_core mbpc_checker u_mbpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.event_code   (out_ch.event_code),
	.event_button (out_ch.event_button)
);
